>>> sv/spsch_pkg.sv
package spsch_pkg;

  // Widths of the payload fields on the channels.
  localparam int SLOT_W = 4;
  localparam int TIME_W = 16;
  localparam int PRIO_W = 8;

  // Command codes of a request word.
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_UPDATE
  } state_t;

  // Control from the sequencer to the priority compare unit.
  typedef struct packed {
    logic clear;
    logic cmp;
  } scan_ctl_t;

endpackage

>>> sv/spsch_req_if.sv
interface spsch_req_if;
  import spsch_pkg::*;

  logic              valid;
  logic              ready;
  logic              cmd;
  logic [SLOT_W-1:0] slot;
  logic [TIME_W-1:0] arrival;
  logic [TIME_W-1:0] burst_length;
  logic [PRIO_W-1:0] prio;

  modport source (output valid, cmd, slot, arrival, burst_length, prio, input ready);
  modport sink (input valid, cmd, slot, arrival, burst_length, prio, output ready);
endinterface

>>> sv/spsch_rsp_if.sv
interface spsch_rsp_if;
  import spsch_pkg::*;

  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] now;
  logic              run_valid;
  logic [SLOT_W-1:0] run_slot;
  logic              finished;
  logic [TIME_W-1:0] wait_total;
  logic [TIME_W-1:0] turnaround;
  logic [TIME_W-1:0] response;
  logic              all_done;

  modport source (output valid, now, run_valid, run_slot, finished, wait_total, turnaround,
                  response, all_done, input ready);
  modport sink (input valid, now, run_valid, run_slot, finished, wait_total, turnaround,
                response, all_done, output ready);
endinterface

>>> sv/preemptive_priority_scheduler_top.sv
// Preemptive priority scheduler.
// The req channel takes one word per command. A load word (cmd low) writes
// arrival, burst length and priority into a task slot and gives no response
// word. A tick word (cmd high) runs one time unit: the slot table is swept
// one slot per cycle through a single priority compare unit, a pace set by
// the one read port of the slot memory and the one compare.
// req.ready is high only while the block is idle, so no request is taken
// while a tick is in progress.
// Each tick produces exactly one rsp word: the tick number, the slot that ran
// (highest priority among arrived, unfinished tasks, lowest slot on a tie),
// and on completion its waiting, turnaround and response times.
// The rsp word sits in an output register; the next request is taken while it
// waits. If the receiver stalls, a following tick finishes its sweep and then
// holds until the previous word has been taken.
// Reset clears the loaded, done and started flags and the tick counter; slot
// memory contents only matter for loaded slots and need no clearing.
module preemptive_priority_scheduler_top #(
  parameter int NUM_SLOTS = 16,
  parameter int TIME_BITS = 16,
  parameter int PRIO_BITS = 8
) (
  input logic        clk,
  input logic        rst,
  spsch_req_if.sink  req,
  spsch_rsp_if.source rsp
);
  import spsch_pkg::*;

  localparam int IW    = $clog2(NUM_SLOTS);
  localparam int PW    = $clog2(NUM_SLOTS + 1);
  localparam int REC_W = 5 * TIME_BITS + PRIO_BITS;
  // Record layout, least significant first.
  localparam int RSP_LO = 0;
  localparam int WAI_LO = TIME_BITS;
  localparam int END_LO = 2 * TIME_BITS;
  localparam int PRI_LO = 3 * TIME_BITS;
  localparam int REM_LO = 3 * TIME_BITS + PRIO_BITS;
  localparam int ARR_LO = 4 * TIME_BITS + PRIO_BITS;

  state_t state, state_next;

  logic [NUM_SLOTS-1:0] loaded;
  logic [NUM_SLOTS-1:0] done;
  logic [NUM_SLOTS-1:0] started;
  logic [TIME_BITS-1:0] time_now;
  logic [IW-1:0]        scan_idx, scan_idx_next;
  logic                 cmp_valid;
  logic [IW-1:0]        cmp_idx;

  logic                 load_go;
  logic [IW-1:0]        load_idx;
  logic [TIME_BITS-1:0] load_arr;
  logic [TIME_BITS-1:0] load_len;
  logic [REC_W-1:0]     load_rec;
  logic                 tick_go;
  logic                 out_free;
  logic                 commit;

  logic                 ram_we;
  logic [IW-1:0]        ram_waddr;
  logic [REC_W-1:0]     ram_wdata;
  logic [REC_W-1:0]     ram_rdata;

  scan_ctl_t            ctl;
  logic                 have;
  logic [IW-1:0]        best_idx;
  logic [REC_W-1:0]     best_rec;
  logic [PW-1:0]        pending;

  logic [TIME_BITS-1:0] remaining_next;
  logic [TIME_BITS-1:0] last_end_next;
  logic [TIME_BITS-1:0] waited_next;
  logic [TIME_BITS-1:0] response_next;
  logic [TIME_BITS-1:0] turnaround;
  logic                 upd_fin;
  logic                 fin;
  logic [REC_W-1:0]     upd_rec;

  assign load_go  = req.valid && req.ready && (req.cmd == CMD_LOAD)
                    && (32'(req.slot) < NUM_SLOTS);
  assign tick_go  = req.valid && req.ready && (req.cmd == CMD_TICK);
  assign load_idx = IW'(req.slot);
  assign load_arr = TIME_BITS'(req.arrival);
  assign load_len = TIME_BITS'(req.burst_length);
  assign load_rec = {load_arr, load_len, PRIO_BITS'(req.prio), load_arr,
                     {TIME_BITS{1'b0}}, {TIME_BITS{1'b0}}};

  assign out_free = !rsp.valid || rsp.ready;
  assign commit   = (state == ST_UPDATE) && out_free;
  assign fin      = have && upd_fin;

  assign upd_rec = {best_rec[ARR_LO +: TIME_BITS], remaining_next,
                    best_rec[PRI_LO +: PRIO_BITS], last_end_next, waited_next,
                    response_next};

  assign ram_we    = load_go || (commit && have);
  assign ram_waddr = load_go ? load_idx : best_idx;
  assign ram_wdata = load_go ? load_rec : upd_rec;

  assign ctl.clear = (state == ST_IDLE);
  assign ctl.cmp   = cmp_valid;

  always_comb begin
    state_next    = state;
    scan_idx_next = scan_idx;
    req.ready     = 1'b0;
    case (state)
      ST_IDLE: begin
        req.ready     = 1'b1;
        scan_idx_next = '0;
        if (tick_go) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        scan_idx_next = scan_idx + 1'b1;
        if (scan_idx == IW'(NUM_SLOTS - 1)) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      scan_idx  <= '0;
      cmp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      scan_idx  <= scan_idx_next;
      cmp_valid <= (state == ST_SCAN);
    end
  end

  // Index that matches the memory word, which arrives in the cycle after its address.
  always_ff @(posedge clk) begin
    cmp_idx <= scan_idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      loaded   <= '0;
      done     <= '0;
      started  <= '0;
      time_now <= '0;
    end else begin
      if (load_go) begin
        loaded[load_idx]  <= 1'b1;
        done[load_idx]    <= (load_len == '0);
        started[load_idx] <= 1'b0;
      end
      if (commit) begin
        if (have) begin
          started[best_idx] <= 1'b1;
          if (upd_fin) begin
            done[best_idx] <= 1'b1;
          end
        end
        if (time_now != '1) begin
          time_now <= time_now + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (commit) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  // The slot that runs is itself pending, so all tasks are done afterwards
  // when nothing was pending, or only that slot was and it has just finished.
  always_ff @(posedge clk) begin
    if (commit) begin
      rsp.now        <= TIME_W'(time_now);
      rsp.run_valid  <= have;
      rsp.run_slot   <= have ? SLOT_W'(best_idx) : '0;
      rsp.finished   <= fin;
      rsp.wait_total <= fin ? TIME_W'(waited_next) : '0;
      rsp.turnaround <= fin ? TIME_W'(turnaround) : '0;
      rsp.response   <= fin ? TIME_W'(response_next) : '0;
      rsp.all_done   <= (pending == '0) || ((pending == PW'(1)) && fin);
    end
  end

  spsch_ram #(
    .WIDTH (REC_W),
    .DEPTH (NUM_SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (scan_idx),
    .rdata (ram_rdata)
  );

  spsch_pick #(
    .NUM_SLOTS (NUM_SLOTS),
    .TIME_BITS (TIME_BITS),
    .PRIO_BITS (PRIO_BITS),
    .REC_W     (REC_W)
  ) u_pick (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .cand_idx     (cmp_idx),
    .cand_pending (loaded[cmp_idx] && !done[cmp_idx]),
    .cand_arrival (ram_rdata[ARR_LO +: TIME_BITS]),
    .cand_prio    (ram_rdata[PRI_LO +: PRIO_BITS]),
    .cand_rec     (ram_rdata),
    .now          (time_now),
    .have         (have),
    .best_idx     (best_idx),
    .best_rec     (best_rec),
    .pending      (pending)
  );

  spsch_upd #(
    .TIME_BITS (TIME_BITS)
  ) u_upd (
    .now            (time_now),
    .started        (started[best_idx]),
    .arrival        (best_rec[ARR_LO +: TIME_BITS]),
    .remaining      (best_rec[REM_LO +: TIME_BITS]),
    .last_end       (best_rec[END_LO +: TIME_BITS]),
    .waited         (best_rec[WAI_LO +: TIME_BITS]),
    .response       (best_rec[RSP_LO +: TIME_BITS]),
    .remaining_next (remaining_next),
    .last_end_next  (last_end_next),
    .waited_next    (waited_next),
    .response_next  (response_next),
    .turnaround     (turnaround),
    .finished       (upd_fin)
  );

endmodule

>>> sv/spsch_ram.sv
module spsch_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/spsch_pick.sv
module spsch_pick #(
  parameter int NUM_SLOTS = 16,
  parameter int TIME_BITS = 16,
  parameter int PRIO_BITS = 8,
  parameter int REC_W     = 88
) (
  input  logic                           clk,
  input  logic                           rst,
  input  spsch_pkg::scan_ctl_t           ctl,
  input  logic [$clog2(NUM_SLOTS)-1:0]   cand_idx,
  input  logic                           cand_pending,
  input  logic [TIME_BITS-1:0]           cand_arrival,
  input  logic [PRIO_BITS-1:0]           cand_prio,
  input  logic [REC_W-1:0]               cand_rec,
  input  logic [TIME_BITS-1:0]           now,
  output logic                           have,
  output logic [$clog2(NUM_SLOTS)-1:0]   best_idx,
  output logic [REC_W-1:0]               best_rec,
  output logic [$clog2(NUM_SLOTS+1)-1:0] pending
);
  import spsch_pkg::*;

  logic [PRIO_BITS-1:0] best_prio;
  logic                 eligible;
  logic                 win;

  // Strictly greater keeps the earlier, lower slot on a tie.
  assign eligible = cand_pending && (cand_arrival <= now);
  assign win      = eligible && (!have || (cand_prio > best_prio));

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      have    <= 1'b0;
      pending <= '0;
    end else if (ctl.cmp) begin
      if (win) begin
        have <= 1'b1;
      end
      if (cand_pending) begin
        pending <= pending + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.cmp && win) begin
      best_idx  <= cand_idx;
      best_rec  <= cand_rec;
      best_prio <= cand_prio;
    end
  end

endmodule

>>> sv/spsch_upd.sv
module spsch_upd #(
  parameter int TIME_BITS = 16
) (
  input  logic [TIME_BITS-1:0] now,
  input  logic                 started,
  input  logic [TIME_BITS-1:0] arrival,
  input  logic [TIME_BITS-1:0] remaining,
  input  logic [TIME_BITS-1:0] last_end,
  input  logic [TIME_BITS-1:0] waited,
  input  logic [TIME_BITS-1:0] response,
  output logic [TIME_BITS-1:0] remaining_next,
  output logic [TIME_BITS-1:0] last_end_next,
  output logic [TIME_BITS-1:0] waited_next,
  output logic [TIME_BITS-1:0] response_next,
  output logic [TIME_BITS-1:0] turnaround,
  output logic                 finished
);
  import spsch_pkg::*;

  function automatic logic [TIME_BITS-1:0] sat_add(input logic [TIME_BITS-1:0] a,
                                                    input logic [TIME_BITS-1:0] b);
    logic [TIME_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_BITS] ? '1 : s[TIME_BITS-1:0];
  endfunction

  function automatic logic [TIME_BITS-1:0] diff_or_zero(input logic [TIME_BITS-1:0] a,
                                                         input logic [TIME_BITS-1:0] b);
    return (a >= b) ? (a - b) : '0;
  endfunction

  logic [TIME_BITS-1:0] since_arrival;

  always_comb begin
    since_arrival  = diff_or_zero(now, arrival);
    response_next  = started ? response : since_arrival;
    waited_next    = sat_add(waited, diff_or_zero(now, last_end));
    last_end_next  = sat_add(now, TIME_BITS'(1));
    remaining_next = (remaining != '0) ? remaining - 1'b1 : remaining;
    finished       = (remaining_next == '0);
    turnaround     = sat_add(since_arrival, TIME_BITS'(1));
  end

endmodule
